// File: sv/hce_pkg.sv
// Package for the histogram CDF engine: sizes, op and status codes,
// register indexes and the structs passed between the front, back and result queue.
// No dependencies.
`timescale 1ns / 1ps
package hce_pkg;
    localparam int NUM_BINS   = 256;
    localparam int NUM_LEVELS = 256;
    localparam int BIN_W      = 8;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_REM   = 3'd1;
    localparam logic [2:0] OP_CLEAR = 3'd2;
    localparam logic [2:0] OP_BUILD = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CLAMP   = 2'd1;
    localparam logic [1:0] ST_SUB_SAT = 2'd2;
    localparam logic [1:0] ST_ADD_SAT = 2'd3;

    localparam logic [1:0] REG_LOWER  = 2'd0;
    localparam logic [1:0] REG_SCALE  = 2'd1;
    localparam logic [1:0] REG_BINS   = 2'd2;
    localparam logic [1:0] REG_LEVELS = 2'd3;

    typedef struct packed {
        logic               is_add;
        logic               is_rem;
        logic               is_clr;
        logic               is_bld;
        logic signed [15:0] sample;
        logic [15:0]        weight;
        logic [7:0]         index;
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] lower;
        logic [31:0]        scale;
        logic [BIN_W-1:0]   nbm1;
        logic [BIN_W-1:0]   nlm1;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  bin;
        logic [31:0] count;
        logic [31:0] cum;
        logic [7:0]  lvl;
        logic [31:0] total;
        logic [1:0]  status;
    } t_res;
endpackage

// File: sv/hce_front.sv
// Front of the histogram CDF engine: input item queue and op classification.
// Depends on hce_pkg.
`timescale 1ns / 1ps
module hce_front import hce_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [2:0]         i_op,
    input  logic signed [15:0] i_sample,
    input  logic [15:0]        i_weight,
    input  logic [7:0]         i_index,
    output logic               o_valid,
    output t_cmd               o_cmd,
    input  logic               i_take
);
    t_cmd       r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push, w_take;

    always_comb begin
        w_cmd        = '0;
        w_cmd.sample = i_sample;
        w_cmd.weight = i_weight;
        w_cmd.index  = i_index;
        case (i_op)
            OP_ADD:   w_cmd.is_add = 1'b1;
            OP_REM:   w_cmd.is_rem = 1'b1;
            OP_CLEAR: w_cmd.is_clr = 1'b1;
            OP_BUILD: w_cmd.is_bld = 1'b1;
            default:  w_cmd.is_add = 1'b0;
        endcase
    end

    assign o_full  = (r_cnt == 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_cmd   = r_q[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_take  = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 2'd1;
            if (w_take) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b0, w_push} - {2'b0, w_take};
        end
    end
endmodule

// File: sv/hce_resq.sv
// Result queue of the histogram CDF engine: two-entry queue toward the result ports.
// Depends on hce_pkg.
`timescale 1ns / 1ps
module hce_resq import hce_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_res i_res,
    output logic o_free,
    output logic o_empty,
    input  logic i_pop,
    output t_res o_res
);
    t_res       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign o_free  = (r_cnt != 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_res   = r_q[r_rp];
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_wr) r_q[r_wp] <= i_res;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_wr} - {1'b0, w_pop};
        end
    end
endmodule

// File: sv/hce_back.sv
// Back of the histogram CDF engine: op sequencer, bin/cumulative/level memories,
// build passes and result assembly. Depends on hce_pkg.
`timescale 1ns / 1ps
module hce_back import hce_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_valid,
    input  t_cmd i_cmd,
    output logic o_take,
    input  logic i_free,
    output logic o_wr,
    output t_res o_res
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_WB   = 4'd3;
    localparam logic [3:0] S_B1R  = 4'd4;
    localparam logic [3:0] S_B1W  = 4'd5;
    localparam logic [3:0] S_LR   = 4'd6;
    localparam logic [3:0] S_LM   = 4'd7;
    localparam logic [3:0] S_LC   = 4'd8;

    logic [31:0]      mem_cnt [NUM_BINS];
    logic [31:0]      mem_cum [NUM_BINS];
    logic [BIN_W-1:0] mem_lvl [NUM_LEVELS];

    logic [3:0]          r_state, n_state;
    t_cmd                r_cmd;
    logic [47:0]         r_prod;
    logic                r_neg;
    logic [BIN_W-1:0]    r_bin, r_b, r_i, r_cur;
    logic                r_clamp, r_built;
    logic [31:0]         r_total, r_acc;
    logic [NUM_BINS-1:0] r_bvalid;
    logic [39:0]         r_need, r_lprod;
    logic [31:0]         q_cnt, q_cum;
    logic [BIN_W-1:0]    q_lvl;
    logic                q_bval;

    logic signed [16:0] w_diff;
    logic [31:0]        w_q, w_cnt, w_cnt_new, w_tot_new;
    logic [BIN_W-1:0]   w_bin, w_rd_addr;
    logic               w_clamp, w_sat, w_hit;
    logic [32:0]        w_csum, w_tsum, w_asum;
    logic               cnt_we, cum_we, lvl_we;
    logic [BIN_W-1:0]   cum_wa, lvl_wa, lvl_wd;
    logic [31:0]        cum_wd;

    assign w_diff = {r_cmd.sample[15], r_cmd.sample} - {i_cfg.lower[15], i_cfg.lower};
    assign w_q    = r_prod[47:16];

    always_comb begin
        w_clamp = 1'b0;
        w_bin   = r_cmd.index;
        if (r_cmd.is_add || r_cmd.is_rem) begin
            if (r_neg) begin
                w_bin   = '0;
                w_clamp = (i_cfg.scale != 32'd0);
            end else if (w_q > {24'b0, i_cfg.nbm1}) begin
                w_bin   = i_cfg.nbm1;
                w_clamp = 1'b1;
            end else begin
                w_bin = w_q[BIN_W-1:0];
            end
        end
    end

    always_comb begin
        case (r_state)
            S_RD:          w_rd_addr = w_bin;
            S_B1R, S_LR:   w_rd_addr = r_b;
            default:       w_rd_addr = r_bin;
        endcase
    end

    assign w_cnt  = q_bval ? q_cnt : 32'd0;
    assign w_csum = {1'b0, w_cnt} + {17'b0, r_cmd.weight};
    assign w_tsum = {1'b0, r_total} + {17'b0, r_cmd.weight};
    assign w_asum = {1'b0, r_acc} + {1'b0, w_cnt};
    assign w_hit  = (r_lprod >= r_need);

    always_comb begin
        w_sat     = 1'b0;
        w_cnt_new = w_cnt;
        w_tot_new = r_total;
        if (r_cmd.is_add) begin
            w_cnt_new = w_csum[32] ? 32'hFFFF_FFFF : w_csum[31:0];
            w_tot_new = w_tsum[32] ? 32'hFFFF_FFFF : w_tsum[31:0];
            w_sat     = w_csum[32] || w_tsum[32];
        end else if (r_cmd.is_rem) begin
            w_cnt_new = (w_cnt < {16'b0, r_cmd.weight}) ? 32'd0 : w_cnt - {16'b0, r_cmd.weight};
            w_tot_new = (r_total < {16'b0, r_cmd.weight}) ? 32'd0
                                                         : r_total - {16'b0, r_cmd.weight};
            w_sat     = (w_cnt < {16'b0, r_cmd.weight}) || (r_total < {16'b0, r_cmd.weight});
        end else if (r_cmd.is_clr) begin
            w_cnt_new = '0;
            w_tot_new = '0;
        end
    end

    always_comb begin
        o_res.bin    = r_bin;
        o_res.count  = w_cnt_new;
        o_res.cum    = r_built ? q_cum : 32'd0;
        o_res.lvl    = r_built ? q_lvl : '0;
        o_res.total  = w_tot_new;
        o_res.status = ST_OK;
        if (r_cmd.is_add && w_sat)                      o_res.status = ST_ADD_SAT;
        else if (r_cmd.is_rem && w_sat)                 o_res.status = ST_SUB_SAT;
        else if ((r_cmd.is_add || r_cmd.is_rem) && r_clamp) o_res.status = ST_CLAMP;
    end

    assign o_take = (r_state == S_IDLE) && i_valid && i_free;
    assign o_wr   = (r_state == S_WB);
    assign cnt_we = (r_state == S_WB) && (r_cmd.is_add || r_cmd.is_rem);

    always_comb begin
        cum_we = 1'b0;
        cum_wa = r_b;
        cum_wd = (r_b > i_cfg.nbm1) ? 32'd0 : (w_asum[32] ? 32'hFFFF_FFFF : w_asum[31:0]);
        lvl_we = 1'b0;
        lvl_wa = r_b;
        lvl_wd = '0;
        if (r_state == S_B1W) begin
            cum_we = 1'b1;
            lvl_we = 1'b1;
        end else if (r_state == S_LC && (w_hit || r_b == i_cfg.nbm1)) begin
            lvl_we = 1'b1;
            lvl_wa = r_i;
            lvl_wd = w_hit ? r_b : r_cur;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (o_take) begin
                if (i_cmd.is_add || i_cmd.is_rem) n_state = S_MUL;
                else if (i_cmd.is_bld)            n_state = S_B1R;
                else                              n_state = S_RD;
            end
            S_MUL:  n_state = S_RD;
            S_RD:   n_state = S_WB;
            S_WB:   n_state = S_IDLE;
            S_B1R:  n_state = S_B1W;
            S_B1W:  if (r_b == BIN_W'(NUM_BINS - 1)) n_state = (r_total == 32'd0) ? S_RD : S_LR;
                    else n_state = S_B1R;
            S_LR:   n_state = S_LM;
            S_LM:   n_state = S_LC;
            S_LC:   if ((w_hit || r_b == i_cfg.nbm1) && r_i == i_cfg.nlm1) n_state = S_RD;
                    else n_state = S_LR;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        q_cnt  <= mem_cnt[w_rd_addr];
        q_cum  <= mem_cum[w_rd_addr];
        q_lvl  <= mem_lvl[w_rd_addr];
        if (cnt_we) mem_cnt[r_bin] <= w_cnt_new;
        if (cum_we) mem_cum[cum_wa] <= cum_wd;
        if (lvl_we) mem_lvl[lvl_wa] <= lvl_wd;
    end

    always_ff @(posedge i_clk) begin
        if (o_take) r_cmd <= i_cmd;
        if (r_state == S_MUL) begin
            r_prod <= {32'b0, 16'(w_diff)} * {16'b0, i_cfg.scale};
            r_neg  <= w_diff[16];
        end
        if (r_state == S_RD) begin
            r_bin   <= w_bin;
            r_clamp <= w_clamp;
        end
        if (r_state == S_LR) r_need <= {32'b0, r_i} * {8'b0, r_total};
        if (r_state == S_LM) r_lprod <= {8'b0, q_cum} * {32'b0, i_cfg.nlm1};
        if (r_state == S_IDLE) begin
            r_b   <= '0;
            r_acc <= '0;
        end
        if (r_state == S_B1W) begin
            r_acc <= cum_wd;
            r_b   <= r_b + 1'b1;
            r_i   <= BIN_W'(1);
            r_cur <= '0;
        end
        if (r_state == S_LC) begin
            if (w_hit) begin
                r_cur <= r_b;
                r_i   <= r_i + 1'b1;
            end else if (r_b == i_cfg.nbm1) begin
                r_b <= r_cur;
                r_i <= r_i + 1'b1;
            end else begin
                r_b <= r_b + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_total  <= '0;
            r_built  <= 1'b0;
            r_bvalid <= '0;
            q_bval   <= 1'b0;
        end else begin
            r_state <= n_state;
            q_bval  <= r_bvalid[w_rd_addr];
            if (r_state == S_IDLE && o_take && i_cmd.is_bld) r_built <= 1'b1;
            if (r_state == S_WB) begin
                r_total <= w_tot_new;
                if (r_cmd.is_clr) r_bvalid <= '0;
                if (cnt_we) r_bvalid[r_bin] <= 1'b1;
            end
        end
    end
endmodule

// File: sv/histogram_cdf_engine.sv
// Histogram CDF engine top level: configuration registers, front, back, result queue.
// Depends on hce_pkg, hce_front, hce_back, hce_resq.
//
// Items enter a four-entry queue and are carried out one at a time. Add and remove step
// through multiply, bin select, memory read and update; clear, read and undefined ops
// skip the multiply. Build walks all 256 bins, then, when the total is nonzero, searches
// the inverse table, one probe per level from 1 up plus one per bin stepped over, then
// does a read at index. Results wait in a two-entry queue.
`timescale 1ns / 1ps
module histogram_cdf_engine import hce_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         i_op,
    input  logic signed [15:0] i_sample,
    input  logic [15:0]        i_weight,
    input  logic [7:0]         i_index,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         o_bin,
    output logic [31:0]        o_count,
    output logic [31:0]        o_cumulative,
    output logic [7:0]         o_level_bin,
    output logic [31:0]        o_total,
    output logic [1:0]         o_status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    logic signed [15:0] r_lower;
    logic [31:0]        r_scale;
    logic [8:0]         r_bins, r_levels;
    t_cfg               w_cfg;
    t_cmd               w_cmd;
    t_res               w_res, w_out;
    logic               w_valid, w_take, w_free, w_wr;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower  <= '0;
            r_scale  <= 32'h0001_0000;
            r_bins   <= 9'd256;
            r_levels <= 9'd256;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_LOWER:  r_lower  <= pwdata[15:0];
                REG_SCALE:  r_scale  <= pwdata;
                REG_BINS:   r_bins   <= pwdata[8:0];
                REG_LEVELS: r_levels <= pwdata[8:0];
                default:    r_lower  <= r_lower;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LOWER:  prdata = {16'b0, r_lower};
            REG_SCALE:  prdata = r_scale;
            REG_BINS:   prdata = {23'b0, r_bins};
            REG_LEVELS: prdata = {23'b0, r_levels};
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        w_cfg.lower = r_lower;
        w_cfg.scale = r_scale;
        if (r_bins < 9'd2)                     w_cfg.nbm1 = BIN_W'(1);
        else if (r_bins > 9'(NUM_BINS))        w_cfg.nbm1 = BIN_W'(NUM_BINS - 1);
        else                                   w_cfg.nbm1 = BIN_W'(r_bins - 9'd1);
        if (r_levels < 9'd2)                   w_cfg.nlm1 = BIN_W'(1);
        else if (r_levels > 9'(NUM_LEVELS))    w_cfg.nlm1 = BIN_W'(NUM_LEVELS - 1);
        else                                   w_cfg.nlm1 = BIN_W'(r_levels - 9'd1);
    end

    hce_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_op(i_op), .i_sample(i_sample), .i_weight(i_weight), .i_index(i_index),
        .o_valid(w_valid), .o_cmd(w_cmd), .i_take(w_take)
    );

    hce_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(w_cfg), .i_valid(w_valid),
        .i_cmd(w_cmd), .o_take(w_take), .i_free(w_free), .o_wr(w_wr), .o_res(w_res)
    );

    hce_resq u_resq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(w_wr), .i_res(w_res), .o_free(w_free),
        .o_empty(empty), .i_pop(pop), .o_res(w_out)
    );

    assign o_bin        = w_out.bin;
    assign o_count      = w_out.count;
    assign o_cumulative = w_out.cum;
    assign o_level_bin  = w_out.lvl;
    assign o_total      = w_out.total;
    assign o_status     = w_out.status;
endmodule

// File: sv/hce_checker.sv
// Port-level checker for the histogram CDF engine, bound to the top level.
// Depends on hce_pkg and histogram_cdf_engine.
`timescale 1ns / 1ps
module hce_checker import hce_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [31:0] o_count,
    input logic [31:0] o_total,
    input logic [1:0]  o_status
);
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_total) && $stable(o_count)))
        else $error("waiting item changed");
    a_sub_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == ST_SUB_SAT) |-> (o_count == 32'd0 || o_total == 32'd0))
        else $error("remove saturation without a zero");
    a_add_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == ST_ADD_SAT)
            |-> (o_count == 32'hFFFF_FFFF || o_total == 32'hFFFF_FFFF))
        else $error("add saturation without a full value");
endmodule

bind histogram_cdf_engine hce_checker u_hce_checker (.*);

// File: tb/hce_checker.sv
// Checker for the histogram CDF engine: snoops the configuration port and both queues,
// predicts every result and compares it field by field. Depends on hce_pkg.
`timescale 1ns / 1ps
module hce_scoreboard import hce_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  logic               full,
    input  logic [2:0]         i_op,
    input  logic signed [15:0] i_sample,
    input  logic [15:0]        i_weight,
    input  logic [7:0]         i_index,
    input  logic               empty,
    input  logic               pop,
    input  logic [7:0]         o_bin,
    input  logic [31:0]        o_count,
    input  logic [31:0]        o_cumulative,
    input  logic [7:0]         o_level_bin,
    input  logic [31:0]        o_total,
    input  logic [1:0]         o_status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 fail_count,
    output int                 pending
);
    logic [31:0]        hist_cnt [NUM_BINS];
    logic [31:0]        hist_cum [NUM_BINS];
    logic [7:0]         level_map [NUM_LEVELS];
    logic [31:0]        weight_sum;
    logic signed [15:0] lower_r;
    logic [31:0]        scale_r;
    logic [8:0]         bins_r;
    logic [8:0]         levels_r;
    t_res               result_q[$];

    function automatic int eff_size(logic [8:0] v, int top);
        if (v < 2) return 2;
        if (v > top) return top;
        return v;
    endfunction

    task automatic build_tables(int nb, int nl);
        longint unsigned acc;
        longint unsigned need;
        int cur;
        acc = 0;
        cur = 0;
        for (int b = 0; b < NUM_BINS; b++) begin
            if (b < nb) begin
                acc += hist_cnt[b];
                if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
                hist_cum[b] = acc[31:0];
            end else begin
                hist_cum[b] = '0;
            end
        end
        for (int i = 0; i < NUM_LEVELS; i++) level_map[i] = '0;
        if (weight_sum != 0) begin
            for (int i = 1; i < nl; i++) begin
                need = longint'(i) * weight_sum;
                level_map[i] = cur[7:0];
                for (int b = cur; b < nb; b++) begin
                    if (64'(hist_cum[b]) * 64'(nl - 1) >= need) begin
                        cur = b;
                        level_map[i] = b[7:0];
                        break;
                    end
                end
            end
        end
    endtask

    task automatic predict_item(output t_res r);
        int nb;
        int nl;
        logic signed [16:0] diff;
        longint unsigned q;
        longint unsigned c;
        longint unsigned t;
        int pos;
        logic clamped;
        logic sat;
        nb = eff_size(bins_r, NUM_BINS);
        nl = eff_size(levels_r, NUM_LEVELS);
        pos = i_index;
        r.status = ST_OK;
        if (i_op == OP_ADD || i_op == OP_REM) begin
            diff = i_sample - lower_r;
            clamped = 1'b0;
            sat = 1'b0;
            if (diff < 0) begin
                clamped = (scale_r != 0);
                pos = 0;
            end else begin
                q = (64'(diff[15:0]) * 64'(scale_r)) >> 16;
                if (q > nb - 1) begin
                    clamped = 1'b1;
                    pos = nb - 1;
                end else begin
                    pos = int'(q);
                end
            end
            if (i_op == OP_ADD) begin
                c = 64'(hist_cnt[pos]) + i_weight;
                t = 64'(weight_sum) + i_weight;
                if (c > 64'hFFFF_FFFF) begin c = 64'hFFFF_FFFF; sat = 1'b1; end
                if (t > 64'hFFFF_FFFF) begin t = 64'hFFFF_FFFF; sat = 1'b1; end
                hist_cnt[pos] = c[31:0];
                weight_sum = t[31:0];
                if (sat) r.status = ST_ADD_SAT;
            end else begin
                if (hist_cnt[pos] < i_weight) begin
                    hist_cnt[pos] = '0;
                    sat = 1'b1;
                end else begin
                    hist_cnt[pos] -= i_weight;
                end
                if (weight_sum < i_weight) begin
                    weight_sum = '0;
                    sat = 1'b1;
                end else begin
                    weight_sum -= i_weight;
                end
                if (sat) r.status = ST_SUB_SAT;
            end
            if (!sat && clamped) r.status = ST_CLAMP;
        end else if (i_op == OP_CLEAR) begin
            for (int b = 0; b < NUM_BINS; b++) hist_cnt[b] = '0;
            weight_sum = '0;
        end else if (i_op == OP_BUILD) begin
            build_tables(nb, nl);
        end
        r.bin   = pos[7:0];
        r.count = hist_cnt[pos];
        r.cum   = hist_cum[pos];
        r.lvl   = level_map[pos];
        r.total = weight_sum;
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res r;
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BINS; b++) begin
                hist_cnt[b] = '0;
                hist_cum[b] = '0;
                level_map[b] = '0;
            end
            weight_sum = '0;
            lower_r = '0;
            scale_r = 32'd65536;
            bins_r = 9'd256;
            levels_r = 9'd256;
            result_q.delete();
            fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_LOWER:  lower_r = pwdata[15:0];
                    REG_SCALE:  scale_r = pwdata;
                    REG_BINS:   bins_r = pwdata[8:0];
                    REG_LEVELS: levels_r = pwdata[8:0];
                    default: ;
                endcase
            end
            if (pop && !empty) begin
                if (result_q.size() == 0) begin
                    $display("%0t: result with none expected, actual bin %0d total %0d",
                             $time, o_bin, o_total);
                    fail_count++;
                end else begin
                    r = result_q.pop_front();
                    compare_field("bin", r.bin, o_bin);
                    compare_field("count", r.count, o_count);
                    compare_field("cumulative", r.cum, o_cumulative);
                    compare_field("level_bin", r.lvl, o_level_bin);
                    compare_field("total", r.total, o_total);
                    compare_field("status", r.status, o_status);
                end
            end
            if (push && !full) begin
                predict_item(r);
                result_q.push_back(r);
            end
        end
        pending = result_q.size();
    end
endmodule

// File: tb/tb.sv
// Testbench top for the histogram CDF engine: clock, reset, stimulus, configuration
// phases and verdict. Depends on hce_pkg, histogram_cdf_engine and hce_scoreboard.
`timescale 1ns / 1ps
module tb;
    import hce_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [2:0]         i_op = OP_READ;
    logic signed [15:0] i_sample = '0;
    logic [15:0]        i_weight = '0;
    logic [7:0]         i_index = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [7:0]         o_bin;
    logic [31:0]        o_count;
    logic [31:0]        o_cumulative;
    logic [7:0]         o_level_bin;
    logic [31:0]        o_total;
    logic [1:0]         o_status;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;
    bit                 no_idle = 1'b0;
    bit                 hold_req = 1'b0;
    int                 stall_cycles = 0;

    always #5 i_clk = ~i_clk;

    histogram_cdf_engine dut (.*);
    hce_scoreboard chk (.*);

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall_cycles = 400;
            end
            if (stall_cycles > 0) begin
                stall_cycles--;
                pop <= 1'b0;
            end else begin
                pop <= no_idle ? 1'b1 : ($urandom_range(99) >= 16);
            end
        end
    end

    always @(posedge i_clk) begin
        int quiet;
        if (!i_rst_n || (push && !full) || (pop && !empty)) quiet = 0;
        else quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("[histogram_cdf_engine] ERROR");
            $finish;
        end
    end

    task automatic send_item(logic [2:0] op, logic [15:0] sample, logic [15:0] weight,
                             logic [7:0] index);
        while (!no_idle && $urandom_range(99) < 16) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push     <= 1'b1;
        i_op     <= op;
        i_sample <= sample;
        i_weight <= weight;
        i_index  <= index;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(logic [15:0] lower, logic [31:0] scale, logic [8:0] nbins,
                             logic [8:0] nlevels);
        drain();
        reg_write(REG_LOWER, {16'(0), lower});
        reg_write(REG_SCALE, scale);
        reg_write(REG_BINS, {23'(0), nbins});
        reg_write(REG_LEVELS, {23'(0), nlevels});
        @(posedge i_clk);
    endtask

    task automatic random_item(logic [15:0] lower);
        int sel;
        logic [2:0]  op;
        logic [15:0] sample;
        logic [15:0] weight;
        sel = $urandom_range(99);
        if (sel < 42) op = OP_ADD;
        else if (sel < 62) op = OP_REM;
        else if (sel < 88) op = OP_READ;
        else if (sel < 93) op = OP_BUILD;
        else if (sel < 95) op = OP_CLEAR;
        else op = 3'($urandom_range(7, 5));
        sel = $urandom_range(9);
        if (sel < 7) sample = lower + 16'($urandom_range(300));
        else sample = 16'($urandom);
        sel = $urandom_range(19);
        if (sel == 0) weight = '0;
        else if (sel < 17) weight = 16'($urandom_range(16, 1));
        else weight = 16'($urandom);
        send_item(op, sample, weight, 8'($urandom));
    endtask

    initial begin
        logic [15:0] lo;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: default registers, scale 1.0
        send_item(OP_READ, 16'd0, 16'd0, 8'd255);
        send_item(OP_ADD, 16'd0, 16'd1, 8'd0);
        send_item(OP_ADD, 16'd255, 16'd65535, 8'd0);
        send_item(OP_ADD, 16'h8000, 16'd3, 8'd0);
        send_item(OP_ADD, 16'h7FFF, 16'd5, 8'd0);
        send_item(OP_ADD, 16'd100, 16'd40, 8'd0);
        send_item(OP_REM, 16'd100, 16'd10, 8'd0);
        send_item(OP_REM, 16'd7, 16'd2, 8'd0);
        send_item(OP_REM, 16'h8000, 16'd65535, 8'd0);
        send_item(OP_BUILD, 16'd0, 16'd0, 8'd100);
        send_item(OP_READ, 16'd0, 16'd0, 8'd128);
        send_item(OP_READ, 16'd0, 16'd0, 8'd254);
        send_item(3'd5, 16'd0, 16'd9, 8'd100);
        send_item(3'd6, 16'd0, 16'd9, 8'd255);
        send_item(3'd7, 16'hFFFF, 16'hFFFF, 8'd0);
        send_item(OP_CLEAR, 16'd0, 16'd0, 8'd100);
        send_item(OP_READ, 16'd0, 16'd0, 8'd100);
        send_item(OP_BUILD, 16'd0, 16'd0, 8'd7);

        // zero scale, smallest sizes
        configure(16'h8000, 32'd0, 9'd2, 9'd2);
        send_item(OP_ADD, 16'h8000, 16'd4, 8'd0);
        send_item(OP_ADD, 16'h7FFF, 16'd4, 8'd0);
        send_item(OP_BUILD, 16'd0, 16'd0, 8'd1);
        send_item(OP_READ, 16'd0, 16'd0, 8'd1);

        // build up a large count and total, then underflow
        configure(16'd0, 32'd65536, 9'd256, 9'd256);
        no_idle = 1'b1;
        send_item(OP_CLEAR, 16'd0, 16'd0, 8'd0);
        repeat (20) send_item(OP_ADD, 16'd5, 16'hFFFF, 8'd0);
        send_item(OP_BUILD, 16'd0, 16'd0, 8'd5);
        send_item(OP_REM, 16'd6, 16'hFFFF, 8'd0);
        send_item(OP_CLEAR, 16'd0, 16'd0, 8'd0);
        no_idle = 1'b0;

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: configure(16'hFF9C, 32'd65536 * 3, 9'd16, 9'd8);
                1: configure(16'h8000, 32'hFFFF_FFFF, 9'd256, 9'd256);
                2: configure(16'h7FFF, 32'd1 << 12, 9'd511, 9'd1);
                3: configure(16'd0, 32'd1 << 14, 9'd0, 9'd300);
                default: configure(16'($urandom), $urandom_range(1 << 19),
                                   9'($urandom_range(256, 2)), 9'($urandom_range(256, 2)));
            endcase
            lo = chk.lower_r;
            no_idle = (ph == 4);
            if (ph == 1) begin
                hold_req = 1'b1;
            end
            if (ph == 3) begin
                drain();
            end
            repeat (275) random_item(lo);
        end
        no_idle = 1'b0;

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) $display("[histogram_cdf_engine] OK");
        else $display("[histogram_cdf_engine] ERROR");
        $finish;
    end
endmodule
